// File: design/lzwd_pkg.sv
// Shared types and constants for the LZSS window decoder.
package lzwd_pkg;

	localparam int unsigned BYTE_BITS     = 8;
	localparam int unsigned LIT_TOKEN_LEN = 9;
	localparam logic [7:0]  SPACE_CHAR    = 8'h20;

	typedef struct packed {
		logic [7:0] comp_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_seen;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic emit_lit;
		logic emit_end;
		logic copy_rd;
		logic copy_wr;
		logic clr_wr;
	} ctl_cmd_t;

	typedef struct packed {
		logic byte_empty;
		logic done;
		logic lit_done;
		logic match_done;
		logic pos_zero;
		logic copy_last;
		logic clr_last;
		logic out_free;
	} ctl_sts_t;

endpackage

// File: design/lzwd_datapath.sv
// Bit reader, ring window memory, copy pointers and output register.
module lzwd_datapath #(
	parameter int unsigned WINDOW_BITS   = 10,
	parameter int unsigned LENGTH_BITS   = 4,
	parameter int unsigned LITERAL_LIMIT = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwd_pkg::in_item_t  tok_item,
	input  lzwd_pkg::ctl_cmd_t  cmd,
	output lzwd_pkg::ctl_sts_t  sts,
	output logic                dec_valid,
	input  logic                dec_ready,
	output lzwd_pkg::out_item_t dec_item
);

	localparam int unsigned WIN       = 2 ** WINDOW_BITS;
	localparam int unsigned LOOKAHEAD = 2 ** LENGTH_BITS + LITERAL_LIMIT;
	localparam int unsigned PREFILL   = WIN - LOOKAHEAD;
	localparam int unsigned TOK_W     = 1 + WINDOW_BITS + LENGTH_BITS;
	localparam int unsigned CNT_W     = $clog2(TOK_W + 1);
	localparam int unsigned WB        = WINDOW_BITS;
	localparam int unsigned LB        = LENGTH_BITS;

	localparam logic [WB:0]      FILL_FULL  = (WB + 1)'(WIN);
	localparam logic [WB:0]      PREFILL_V  = (WB + 1)'(PREFILL);
	localparam logic [WB-1:0]    CLR_FIRST  = WB'(PREFILL);
	localparam logic [CNT_W-1:0] LIT_LEN_V  = CNT_W'(lzwd_pkg::LIT_TOKEN_LEN);
	localparam logic [CNT_W-1:0] TOK_LEN_V  = CNT_W'(TOK_W);

	logic [7:0]       byte_q;
	logic [3:0]       bits_left_q;
	logic [TOK_W-1:0] token_q;
	logic [CNT_W-1:0] cnt_q;
	logic             flag_q;
	logic             done_q;
	logic [WB-1:0]    wp_q;
	logic [WB:0]      fill_q;
	logic [WB-1:0]    src_q;
	logic [LB:0]      rem_q;
	logic [7:0]       lit_q;
	logic [WB-1:0]    clr_q;
	logic [7:0]       rd_q;
	logic             spc_q;
	logic             out_vld_q;
	lzwd_pkg::out_item_t out_q;

	logic [7:0] win_mem [WIN];

	logic             bit_in;
	logic [TOK_W-1:0] token_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic             flag_nx;
	logic [WB-1:0]    pos;
	logic [LB-1:0]    len;
	logic             lit_done;
	logic             match_done;
	logic             emit_any;
	logic [7:0]       cp_byte;
	logic             win_we;
	logic [WB-1:0]    win_wa;
	logic [7:0]       win_wd;
	logic             start;

	assign start    = cmd.load & tok_item.stream_start;
	assign bit_in   = byte_q[7];
	assign token_nx = {token_q[TOK_W-2:0], bit_in};
	assign cnt_nx   = cnt_q + CNT_W'(1);
	// The first bit of a token is its flag.
	assign flag_nx  = (cnt_q == '0) ? bit_in : flag_q;
	assign pos      = token_nx[LB +: WB];
	assign len      = token_nx[LB-1:0];
	assign lit_done   = flag_nx & (cnt_nx == LIT_LEN_V);
	assign match_done = ~flag_nx & (cnt_nx == TOK_LEN_V);
	assign cp_byte  = spc_q ? lzwd_pkg::SPACE_CHAR : rd_q;
	assign emit_any = cmd.emit_lit | cmd.emit_end | cmd.copy_wr;

	always_comb begin
		sts.byte_empty = (bits_left_q == 4'd0);
		sts.done       = done_q;
		sts.lit_done   = lit_done;
		sts.match_done = match_done;
		sts.pos_zero   = (pos == '0);
		sts.copy_last  = (rem_q == '0);
		sts.clr_last   = (clr_q == {WB{1'b1}});
		sts.out_free   = ~out_vld_q | dec_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= 4'd0;
			token_q     <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			done_q      <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			clr_q       <= CLR_FIRST;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + WB'(1);
			end
			if (cmd.load) begin
				bits_left_q <= 4'd8;
			end else if (cmd.shift) begin
				bits_left_q <= bits_left_q - 4'd1;
			end
			if (start) begin
				token_q <= '0;
				cnt_q   <= '0;
				done_q  <= 1'b0;
				wp_q    <= '0;
				fill_q  <= '0;
			end else begin
				if (cmd.shift) begin
					flag_q <= flag_nx;
					if (lit_done || match_done) begin
						token_q <= '0;
						cnt_q   <= '0;
					end else begin
						token_q <= token_nx;
						cnt_q   <= cnt_nx;
					end
				end
				if (cmd.emit_end) begin
					done_q <= 1'b1;
				end
				if (cmd.emit_lit || cmd.copy_wr) begin
					wp_q <= wp_q + WB'(1);
					if (fill_q != FILL_FULL) begin
						fill_q <= fill_q + (WB + 1)'(1);
					end
				end
			end
		end
	end

	// Payload registers: byte shifter, literal, copy pointers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= tok_item.comp_byte;
		end else if (cmd.shift) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
		if (cmd.shift && lit_done) begin
			lit_q <= token_nx[7:0];
		end
		if (cmd.shift && match_done) begin
			src_q <= pos - WB'(1);
			rem_q <= {1'b0, len} + (LB + 1)'(1);
		end else if (cmd.copy_wr) begin
			src_q <= src_q + WB'(1);
			rem_q <= rem_q - (LB + 1)'(1);
		end
	end

	// Entries below the prefill boundary that this stream has not yet
	// written read as spaces, since writes fill the window in order.
	always_ff @(posedge clk) begin
		if (cmd.copy_rd) begin
			rd_q  <= win_mem[src_q];
			spc_q <= ({1'b0, src_q} < PREFILL_V) && (fill_q <= {1'b0, src_q});
		end
	end

	always_comb begin
		win_we = cmd.clr_wr | cmd.emit_lit | cmd.copy_wr;
		win_wa = cmd.clr_wr ? clr_q : wp_q;
		if (cmd.clr_wr) begin
			win_wd = 8'h00;
		end else if (cmd.emit_lit) begin
			win_wd = lit_q;
		end else begin
			win_wd = cp_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wa] <= win_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_any) begin
			out_vld_q <= 1'b1;
		end else if (dec_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			out_q.out_byte    <= cmd.emit_end ? 8'h00 : (cmd.emit_lit ? lit_q : cp_byte);
			out_q.byte_valid  <= ~cmd.emit_end;
			out_q.end_seen    <= cmd.emit_end;
			out_q.last_of_run <= cmd.emit_lit | cmd.emit_end | (rem_q == '0);
		end
	end

	assign dec_valid = out_vld_q;
	assign dec_item  = out_q;

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.end_seen |-> !out_q.byte_valid)
		else $error("end marker result carries a byte");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < TOK_LEN_V)
		else $error("token bit count overran the token length");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond window size");

	a_end_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_end |=> done_q)
		else $error("end marker did not stop the stream");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_any |-> (!out_vld_q || dec_ready))
		else $error("result loaded over an untaken result");

endmodule

// File: design/lzwd_ctrl.sv
// Controller state machine sequencing bit reading, emission and copies.
module lzwd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_ready,
	input  lzwd_pkg::ctl_sts_t sts,
	output lzwd_pkg::ctl_cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_LIT   = 3'd3;
	localparam logic [2:0] S_END   = 3'd4;
	localparam logic [2:0] S_CRD   = 3'd5;
	localparam logic [2:0] S_CWR   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		tok_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				tok_ready = 1'b1;
				if (tok_valid) begin
					cmd.load = 1'b1;
					state_nx = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.done || sts.byte_empty) begin
					state_nx = S_IDLE;
				end else begin
					cmd.shift = 1'b1;
					if (sts.lit_done) begin
						state_nx = S_LIT;
					end else if (sts.match_done) begin
						state_nx = sts.pos_zero ? S_END : S_CRD;
					end
				end
			end
			S_LIT: begin
				if (sts.out_free) begin
					cmd.emit_lit = 1'b1;
					state_nx     = S_SHIFT;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.emit_end = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_CRD: begin
				cmd.copy_rd = 1'b1;
				state_nx    = S_CWR;
			end
			S_CWR: begin
				if (sts.out_free) begin
					cmd.copy_wr = 1'b1;
					state_nx    = sts.copy_last ? S_SHIFT : S_CRD;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ready |-> !(cmd.shift || cmd.copy_wr || cmd.emit_lit))
		else $error("input taken while a token is in progress");

	a_read_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_rd |=> state_q == S_CWR)
		else $error("copy read not followed by its write step");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT && sts.done |-> !cmd.shift)
		else $error("bits consumed after the end marker");

endmodule

// File: design/lzss_window_decoder.sv
// LZSS window decoder: one compressed byte in, zero to seventeen decoded results out.
// An accepted byte is loaded, then shifted one bit a cycle unless a token waits to be emitted,
// and the block returns to idle once the byte is used up. A literal adds an emit step; a match
// copies each byte by a window read, then a write and emit step. Emit and write steps wait while
// the output holds an untaken result. The end marker ends its byte there; later bytes of that
// stream are taken and dropped. A clearing pass after reset zeroes the last 2**LENGTH_BITS +
// LITERAL_LIMIT (17) window entries before the first byte; the rest read as spaces until written.
module lzss_window_decoder #(
	parameter int unsigned WINDOW_BITS   = 10,
	parameter int unsigned LENGTH_BITS   = 4,
	parameter int unsigned LITERAL_LIMIT = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_ready,
	input  lzwd_pkg::in_item_t  tok_item,
	output logic                dec_valid,
	input  logic                dec_ready,
	output lzwd_pkg::out_item_t dec_item
);

	lzwd_pkg::ctl_cmd_t cmd;
	lzwd_pkg::ctl_sts_t sts;

	lzwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lzwd_datapath #(
		.WINDOW_BITS   (WINDOW_BITS),
		.LENGTH_BITS   (LENGTH_BITS),
		.LITERAL_LIMIT (LITERAL_LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_item  (tok_item),
		.cmd       (cmd),
		.sts       (sts),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_item  (dec_item)
	);

endmodule

// File: dv/lzss_window_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench for the LZSS window decoder: directed and random streams checked against a predictor.
module lzss_window_decoder_tb;

	localparam int unsigned WIN_BITS        = 10;
	localparam int unsigned LEN_BITS        = 4;
	localparam int unsigned LIT_LIMIT       = 1;
	localparam int unsigned WIN_SIZE        = 1 << WIN_BITS;
	localparam int unsigned WIN_MASK        = WIN_SIZE - 1;
	localparam int unsigned LEN_MAX         = (1 << LEN_BITS) - 1;
	localparam int unsigned PREFILL         = WIN_SIZE - (1 << LEN_BITS) - LIT_LIMIT;
	localparam int unsigned MATCH_TOKEN_LEN = 1 + WIN_BITS + LEN_BITS;
	localparam bit          LIT_FLAG        = 1'b1;
	localparam bit          MATCH_FLAG      = 1'b0;
	localparam int unsigned END_POS         = 0;
	localparam int unsigned CLK_HALF        = 4;
	localparam int unsigned ITEM_TARGET     = 350;
	localparam int unsigned IDLE_LIMIT      = 4000;
	localparam int unsigned DRAIN_CYCLES    = 100;

	class decoded_byte_board;
		logic [7:0]                 window [WIN_SIZE];
		logic [WIN_BITS-1:0]        wr_ptr;
		logic [MATCH_TOKEN_LEN-1:0] token;
		logic [3:0]                 nbits;
		bit                         done;
		lzwd_pkg::out_item_t        expected_out [$];
		int unsigned n_err, n_in, n_checked, n_literals, n_matches, n_ends, n_starts;

		function new();
			foreach (window[i]) window[i] = (i < PREFILL) ? lzwd_pkg::SPACE_CHAR : 8'h00;
			wr_ptr = '0;
			token  = '0;
			nbits  = '0;
			done   = 1'b0;
		endfunction

		// Every decoded byte lands in the ring window and goes out.
		function lzwd_pkg::out_item_t store_byte(logic [7:0] b);
			lzwd_pkg::out_item_t r;
			window[wr_ptr] = b;
			wr_ptr++;
			r = '0;
			r.out_byte = b;
			r.byte_valid = 1'b1;
			return r;
		endfunction

		function void take_comp_byte(lzwd_pkg::in_item_t it);
			lzwd_pkg::out_item_t run [$];
			lzwd_pkg::out_item_t tail;
			logic [WIN_BITS-1:0] pos;
			logic [WIN_BITS-1:0] idx;
			logic [LEN_BITS-1:0] len;
			n_in++;
			if (it.stream_start) begin
				n_starts++;
				token  = '0;
				nbits  = '0;
				wr_ptr = '0;
				done   = 1'b0;
				for (int i = 0; i < PREFILL; i++) window[i] = lzwd_pkg::SPACE_CHAR;
			end
			for (int i = lzwd_pkg::BYTE_BITS - 1; i >= 0 && !done; i--) begin
				token = {token[MATCH_TOKEN_LEN-2:0], it.comp_byte[i]};
				nbits++;
				if (token[nbits-1] == LIT_FLAG && nbits == lzwd_pkg::LIT_TOKEN_LEN) begin
					run.push_back(store_byte(token[7:0]));
					n_literals++;
					token = '0;
					nbits = '0;
				end else if (token[nbits-1] == MATCH_FLAG && nbits == MATCH_TOKEN_LEN) begin
					pos   = token[LEN_BITS +: WIN_BITS];
					len   = token[LEN_BITS-1:0];
					token = '0;
					nbits = '0;
					if (pos == END_POS) begin
						tail = '0;
						tail.end_seen = 1'b1;
						run.push_back(tail);
						done = 1'b1;
						n_ends++;
					end else begin
						n_matches++;
						// The copy reads one byte at a time, so it may see bytes it just wrote.
						for (int k = 0; k <= len + 1; k++) begin
							idx = WIN_BITS'(pos - 1 + k);
							run.push_back(store_byte(window[idx]));
						end
					end
				end
			end
			if (run.size() > 0) begin
				tail = run.pop_back();
				tail.last_of_run = 1'b1;
				run.push_back(tail);
			end
			foreach (run[j]) expected_out.push_back(run[j]);
		endfunction

		function void check_decoded(lzwd_pkg::out_item_t got);
			lzwd_pkg::out_item_t want;
			if (expected_out.size() == 0) begin
				$error("decoded result %h arrived with nothing expected", got);
				n_err++;
				return;
			end
			want = expected_out.pop_front();
			n_checked++;
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
				n_err++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
				n_err++;
			end
			if (got.end_seen !== want.end_seen) begin
				$error("end_seen: expected %b, got %b", want.end_seen, got.end_seen);
				n_err++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
				n_err++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                tok_valid;
	logic                tok_ready;
	lzwd_pkg::in_item_t  tok_item;
	logic                dec_valid;
	logic                dec_ready;
	lzwd_pkg::out_item_t dec_item;

	decoded_byte_board sb = new();

	bit          quiet       = 1'b0;
	int unsigned stall_left  = 0;
	int unsigned idle_cycles = 0;
	int unsigned counted     = 0;
	int unsigned sent        = 0;
	int unsigned n_streams   = 0;
	int unsigned gen_ptr     = 0;
	bit          stream_bits [$];

	lzss_window_decoder #(
		.WINDOW_BITS  (WIN_BITS),
		.LENGTH_BITS  (LEN_BITS),
		.LITERAL_LIMIT(LIT_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_item (tok_item),
		.dec_valid(dec_valid),
		.dec_ready(dec_ready),
		.dec_item (dec_item)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Stream encoding. gen_ptr follows the write pointer so matches can aim near it.
	function automatic void put_bits(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
	endfunction

	function automatic void put_literal(logic [7:0] b);
		put_bits(LIT_FLAG, 1);
		put_bits(b, 8);
		gen_ptr = (gen_ptr + 1) & WIN_MASK;
	endfunction

	function automatic void put_match(int unsigned pos, int unsigned len);
		put_bits(MATCH_FLAG, 1);
		put_bits(pos, WIN_BITS);
		put_bits(len, LEN_BITS);
		gen_ptr = (gen_ptr + len + 2) & WIN_MASK;
	endfunction

	function automatic void put_end();
		put_bits(MATCH_FLAG, 1);
		put_bits(END_POS, WIN_BITS);
		put_bits($urandom_range(LEN_MAX), LEN_BITS);
	endfunction

	function automatic int unsigned near_pos(int unsigned back);
		int unsigned p;
		p = ((gen_ptr - back) & WIN_MASK) + 1;
		return (p == WIN_SIZE) ? WIN_SIZE - 1 : p;
	endfunction

	function automatic int unsigned random_match_pos();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return near_pos($urandom_range(4, 1));
		if (r < 40)
			return ($urandom_range(1) == 1) ? 1 : WIN_SIZE - 1;
		if (r < 50)
			return $urandom_range(WIN_SIZE - 1, PREFILL + 1);
		return $urandom_range(WIN_SIZE - 1, 1);
	endfunction

	task automatic send_item(lzwd_pkg::in_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			tok_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_valid <= 1'b1;
		tok_item  <= it;
		do @(posedge clk); while (!tok_ready);
		sb.take_comp_byte(it);
		sent++;
		if (sent % 40 == 0)
			quiet = ($urandom_range(3) == 0);
	endtask

	// Packs the bit queue into bytes; the first byte opens a new stream.
	task automatic send_stream();
		lzwd_pkg::in_item_t it;
		bit                 first;
		first = 1'b1;
		n_streams++;
		while (stream_bits.size() > 0) begin
			it.stream_start = first;
			first = 1'b0;
			for (int i = lzwd_pkg::BYTE_BITS - 1; i >= 0; i--)
				it.comp_byte[i] = (stream_bits.size() > 0) ? stream_bits.pop_front()
				                                           : 1'($urandom_range(1));
			send_item(it);
			counted++;
		end
	endtask

	// Bytes after an end marker are ignored by the block and are not counted.
	task automatic send_ignored(int unsigned n);
		lzwd_pkg::in_item_t it;
		repeat (n) begin
			it.comp_byte    = 8'($urandom_range(255));
			it.stream_start = 1'b0;
			send_item(it);
		end
	endtask

	task automatic send_noise(int unsigned n);
		lzwd_pkg::in_item_t it;
		repeat (n) begin
			it.comp_byte    = 8'($urandom_range(255));
			it.stream_start = ($urandom_range(3) == 0);
			send_item(it);
			counted++;
		end
	endtask

	task automatic random_stream(int unsigned ntok, int unsigned match_pct);
		int unsigned r;
		stream_bits.delete();
		gen_ptr = 0;
		repeat (ntok) begin
			if ($urandom_range(99) < match_pct)
				put_match(random_match_pos(), $urandom_range(LEN_MAX));
			else
				put_literal($urandom_range(255));
		end
		r = $urandom_range(9);
		if (r < 6)
			put_end();
		else if (r < 8)
			put_bits($urandom, $urandom_range(8, 1));
		send_stream();
		if (r < 6 && $urandom_range(1) == 1)
			send_ignored($urandom_range(3, 1));
	endtask

	always @(posedge clk) begin
		if (dec_valid && dec_ready)
			sb.check_decoded(dec_item);
		if (stall_left > 0)
			stall_left--;
		else if (!quiet && $urandom_range(2) == 0)
			stall_left = pick_gap();
		dec_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if ((tok_valid && tok_ready) || (dec_valid && dec_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results still expected.",
			         IDLE_LIMIT, sb.expected_out.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		tok_valid <= 1'b0;
		tok_item  <= '0;
		dec_ready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Literal extremes, matches at both ends of the window, self-overlapping copies,
		// a copy from the window tail, then the end marker followed by bytes to ignore.
		stream_bits.delete();
		gen_ptr = 0;
		put_literal(8'h00);
		put_literal(8'hFF);
		put_match(1, 0);
		put_match(WIN_SIZE - 1, LEN_MAX);
		put_match(near_pos(1), LEN_MAX);
		put_match(near_pos(3), 5);
		put_match(PREFILL + 1, LEN_MAX);
		put_end();
		send_stream();
		send_ignored(2);

		// A match cut short by the next stream start is dropped.
		stream_bits.delete();
		gen_ptr = 0;
		put_literal(8'h41);
		put_bits(MATCH_FLAG, 1);
		put_bits(10'h155, 5);
		send_stream();

		// A stream that is nothing but the end marker.
		stream_bits.delete();
		gen_ptr = 0;
		put_end();
		send_stream();

		// One long match-heavy stream, then mixed streams and noise.
		random_stream(80, 85);
		while (counted < ITEM_TARGET) begin
			if ($urandom_range(9) == 0)
				send_noise($urandom_range(8, 1));
			else
				random_stream($urandom_range(20, 2), $urandom_range(80, 20));
		end
		tok_valid <= 1'b0;

		while (sb.expected_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d compressed bytes in %0d streams: %0d literals, %0d matches, %0d ends.",
		         sb.n_in, n_streams, sb.n_literals, sb.n_matches, sb.n_ends);
		$display("Checked %0d decoded results with %0d stream starts; %0d mismatches.",
		         sb.n_checked, sb.n_starts, sb.n_err);
		if (sb.n_err == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
